[hdl/gdep_pkg.sv]
`timescale 1ns / 1ps
package gdep_pkg;

    localparam int MAX_DIM_DEF     = 64;
    localparam int STACK_DEPTH_DEF = 8192;

    localparam int IN_W      = 24;
    localparam int OUT_W     = 24;
    localparam int CFG_DATA_W = 7;

    localparam logic [7:0] GEN_START = 8'd6;
    localparam logic [7:0] GEN_LAST  = 8'd254;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_PRUNE = 2'd1,
        FUNC_READ  = 2'd2
    } gdep_func_t;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } gdep_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SCAN_START,
        ST_TF_CENTER,
        ST_TF_CWAIT,
        ST_TF_NB,
        ST_TF_NBWAIT,
        ST_TF_EVAL,
        ST_TF_PUSH,
        ST_SCAN_NEXT,
        ST_LOOP_CHK,
        ST_DRAIN,
        ST_POP_WAIT,
        ST_DONE
    } gdep_state_t;

    // Bit m is set when an 8-neighbour blocked mask m allows a fill
    localparam logic [255:0] APPROVE_LUT = {
        32'hE880F880, 32'hEC80FC80, 32'hE8A0F8A0, 32'hECA0FCA0,
        32'hE888F888, 32'hEC88FC88, 32'hE8A8F8A8, 32'hECA8FCA8
    };

    // Neighbour offsets, two-bit signed, bit i of the mask is entry i
    function automatic logic [1:0] nb_dx(input logic [2:0] i);
        logic [1:0] d;
        case (i)
            3'd1, 3'd4, 3'd6: d = 2'b11;
            3'd2, 3'd5, 3'd7: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] nb_dy(input logic [2:0] i);
        logic [1:0] d;
        case (i)
            3'd0, 3'd4, 3'd5: d = 2'b11;
            3'd3, 3'd6, 3'd7: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] gen_step(input logic [7:0] g);
        return (g == GEN_LAST) ? 8'd0 : g + 8'd1;
    endfunction

endpackage

[hdl/grid_dead_end_pruner_unit.sv]
`timescale 1ns / 1ps
// Grid dead-end pruner. A prune scans every cell in use, column by column,
// and then drains two work stacks in turn. Each cell tried takes a center
// read, a read of each neighbour that lies in the map, the table check and,
// when filled, the neighbour pushes; each pop and each step of the scan come
// between cells. The single port of the grid memory and the one shared
// neighbour unit make these steps run one after another; a cell that is
// blocked, the start or the goal skips the neighbour reads. The grid and the
// stacks need no clearing after reset; cells must be written before a prune
// or read touches them. One item is handled at a time, and a new item is
// taken once the previous result has been taken.
module grid_dead_end_pruner_unit import gdep_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // func[1:0], col[7:2], row[13:8], cell_value[21:14]
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_value[7:0], pass_count[16:8], stack_overflow[17]
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int XW  = $clog2(MAX_DIM);
    localparam int GAW = 2 * XW;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);

    logic [1:0] in_func;
    logic [5:0] in_col;
    logic [5:0] in_row;
    logic [7:0] in_value;
    logic       in_addr_ok;

    assign in_func  = s_tdata[1:0];
    assign in_col   = s_tdata[7:2];
    assign in_row   = s_tdata[13:8];
    assign in_value = s_tdata[21:14];
    assign in_addr_ok = (32'(in_col) < MAX_DIM) && (32'(in_row) < MAX_DIM);

    gdep_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] grid_width_reg, grid_width_next;
    logic [CFG_DATA_W-1:0] grid_height_reg, grid_height_next;
    logic [XW-1:0]  cx_reg, cx_next;
    logic [XW-1:0]  cy_reg, cy_next;
    logic [2:0]     nb_idx_reg, nb_idx_next;
    logic [7:0]     mask_reg, mask_next;
    logic [7:0]     inmap_reg, inmap_next;
    logic [7:0]     gen_reg, gen_next;
    logic [CW-1:0]  cnt_a_reg, cnt_a_next;
    logic [CW-1:0]  cnt_b_reg, cnt_b_next;
    logic           scan_reg, scan_next;
    logic           src_b_reg, src_b_next;
    logic           ovf_reg, ovf_next;
    logic           rd_ok_reg, rd_ok_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     read_value_reg, read_value_next;
    logic [8:0]     pass_count_reg, pass_count_next;
    logic           ovf_out_reg, ovf_out_next;

    logic [XW:0]    eff_w;
    logic [XW:0]    eff_h;
    logic [XW-1:0]  nx;
    logic [XW-1:0]  ny;
    logic           nb_in_map;

    logic           grid_we;
    logic [GAW-1:0] grid_addr;
    logic [7:0]     grid_wdata;
    logic [7:0]     grid_rdata;

    logic           sa_we, sb_we;
    logic [SAW-1:0] sa_addr, sb_addr;
    logic [GAW-1:0] stk_wdata;
    logic [GAW-1:0] sa_rdata, sb_rdata;

    logic           is_start;
    logic           is_goal;
    logic           cnt_src_zero;
    logic           dst_b;
    logic [CW-1:0]  dst_cnt;
    logic           push_now;
    gdep_state_t    ret_state;

    assign eff_w = (32'(grid_width_reg) > MAX_DIM) ? (XW+1)'(MAX_DIM)
                                                    : (XW+1)'(grid_width_reg);
    assign eff_h = (32'(grid_height_reg) > MAX_DIM) ? (XW+1)'(MAX_DIM)
                                                     : (XW+1)'(grid_height_reg);

    gdep_nbr #(.MAX_DIM(MAX_DIM)) u_nbr (
        .cx     (cx_reg),
        .cy     (cy_reg),
        .idx    (nb_idx_reg),
        .eff_w  (eff_w),
        .eff_h  (eff_h),
        .nx     (nx),
        .ny     (ny),
        .in_map (nb_in_map)
    );

    gdep_ram #(.WIDTH(8), .DEPTH(1 << GAW)) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .addr  (grid_addr),
        .wdata (grid_wdata),
        .rdata (grid_rdata)
    );

    gdep_ram #(.WIDTH(GAW), .DEPTH(STACK_DEPTH)) u_stack_a (
        .clk   (clk),
        .we    (sa_we),
        .addr  (sa_addr),
        .wdata (stk_wdata),
        .rdata (sa_rdata)
    );

    gdep_ram #(.WIDTH(GAW), .DEPTH(STACK_DEPTH)) u_stack_b (
        .clk   (clk),
        .we    (sb_we),
        .addr  (sb_addr),
        .wdata (stk_wdata),
        .rdata (sb_rdata)
    );

    assign is_start     = (cx_reg == '0) && (cy_reg == '0);
    assign is_goal      = ({1'b0, cx_reg} == eff_w - 1'b1) &&
                          ({1'b0, cy_reg} == eff_h - 1'b1);
    assign cnt_src_zero = src_b_reg ? (cnt_b_reg == '0) : (cnt_a_reg == '0);
    assign dst_b        = !scan_reg && !src_b_reg;
    assign dst_cnt      = dst_b ? cnt_b_reg : cnt_a_reg;
    assign push_now     = (state_reg == ST_TF_PUSH) && inmap_reg[nb_idx_reg] &&
                          !mask_reg[nb_idx_reg];
    assign ret_state    = scan_reg ? ST_SCAN_NEXT : ST_DRAIN;

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, ovf_out_reg, pass_count_reg, read_value_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    if (in_func == FUNC_READ)
                    begin
                        state_next = ST_RD_WAIT;
                    end
                    else if (in_func == FUNC_PRUNE)
                    begin
                        state_next = ST_SCAN_START;
                    end
                end
            end
            ST_RD_WAIT:    state_next = ST_IDLE;
            ST_SCAN_START:
            begin
                if (eff_w == '0 || eff_h == '0)
                begin
                    state_next = ST_LOOP_CHK;
                end
                else
                begin
                    state_next = ST_TF_CENTER;
                end
            end
            ST_TF_CENTER:  state_next = ST_TF_CWAIT;
            ST_TF_CWAIT:
            begin
                if (grid_rdata != '0 || is_start || is_goal)
                begin
                    state_next = ret_state;
                end
                else
                begin
                    state_next = ST_TF_NB;
                end
            end
            ST_TF_NB:
            begin
                if (nb_in_map)
                begin
                    state_next = ST_TF_NBWAIT;
                end
                else if (nb_idx_reg == 3'd7)
                begin
                    state_next = ST_TF_EVAL;
                end
            end
            ST_TF_NBWAIT:
            begin
                state_next = (nb_idx_reg == 3'd7) ? ST_TF_EVAL : ST_TF_NB;
            end
            ST_TF_EVAL:
            begin
                state_next = APPROVE_LUT[mask_reg] ? ST_TF_PUSH : ret_state;
            end
            ST_TF_PUSH:
            begin
                if (nb_idx_reg == 3'd7)
                begin
                    state_next = ret_state;
                end
            end
            ST_SCAN_NEXT:
            begin
                if ({1'b0, cy_reg} == eff_h - 1'b1 && {1'b0, cx_reg} == eff_w - 1'b1)
                begin
                    state_next = ST_LOOP_CHK;
                end
                else
                begin
                    state_next = ST_TF_CENTER;
                end
            end
            ST_LOOP_CHK:
            begin
                state_next = (cnt_a_reg == '0) ? ST_DONE : ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!cnt_src_zero)
                begin
                    state_next = ST_POP_WAIT;
                end
                else if (src_b_reg)
                begin
                    state_next = ST_LOOP_CHK;
                end
            end
            ST_POP_WAIT:   state_next = ST_TF_CENTER;
            ST_DONE:       state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        nb_idx_next      = nb_idx_reg;
        mask_next        = mask_reg;
        inmap_next       = inmap_reg;
        gen_next         = gen_reg;
        cnt_a_next       = cnt_a_reg;
        cnt_b_next       = cnt_b_reg;
        scan_next        = scan_reg;
        src_b_next       = src_b_reg;
        ovf_next         = ovf_reg;
        rd_ok_next       = rd_ok_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        read_value_next  = read_value_reg;
        pass_count_next  = pass_count_reg;
        ovf_out_next     = ovf_out_reg;

        grid_we    = 1'b0;
        grid_addr  = {ny, nx};
        grid_wdata = gen_reg;
        sa_we      = 1'b0;
        sb_we      = 1'b0;
        sa_addr    = cnt_a_reg[SAW-1:0];
        sb_addr    = cnt_b_reg[SAW-1:0];
        stk_wdata  = {ny, nx};

        if (cfg_we)
        begin
            if (cfg_index == REG_GRID_WIDTH)
            begin
                grid_width_next = cfg_data;
            end
            else
            begin
                grid_height_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                grid_addr  = {XW'(in_row), XW'(in_col)};
                grid_wdata = in_value;
                if (s_tvalid && s_tready)
                begin
                    read_value_next = '0;
                    pass_count_next = '0;
                    ovf_out_next    = 1'b0;
                    rd_ok_next      = in_addr_ok;
                    if (in_func == FUNC_WRITE)
                    begin
                        grid_we        = in_addr_ok;
                        out_valid_next = 1'b1;
                    end
                    else if (in_func == FUNC_PRUNE)
                    begin
                        gen_next   = GEN_START;
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        ovf_next   = 1'b0;
                        cx_next    = '0;
                        cy_next    = '0;
                        scan_next  = 1'b1;
                        src_b_next = 1'b0;
                    end
                    else if (in_func != FUNC_READ)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_RD_WAIT:
            begin
                read_value_next = rd_ok_reg ? grid_rdata : 8'd0;
                out_valid_next  = 1'b1;
            end
            ST_TF_CENTER:
            begin
                grid_addr = {cy_reg, cx_reg};
            end
            ST_TF_CWAIT:
            begin
                nb_idx_next = 3'd0;
                mask_next   = '0;
                inmap_next  = '0;
            end
            ST_TF_NB:
            begin
                inmap_next[nb_idx_reg] = nb_in_map;
                if (!nb_in_map)
                begin
                    mask_next[nb_idx_reg] = 1'b1;
                    nb_idx_next = nb_idx_reg + 3'd1;
                end
            end
            ST_TF_NBWAIT:
            begin
                mask_next[nb_idx_reg] = (grid_rdata != '0);
                nb_idx_next = nb_idx_reg + 3'd1;
            end
            ST_TF_EVAL:
            begin
                grid_addr   = {cy_reg, cx_reg};
                grid_wdata  = gen_reg;
                grid_we     = APPROVE_LUT[mask_reg];
                nb_idx_next = 3'd0;
            end
            ST_TF_PUSH:
            begin
                nb_idx_next = nb_idx_reg + 3'd1;
                if (push_now)
                begin
                    if (32'(dst_cnt) < STACK_DEPTH)
                    begin
                        if (dst_b)
                        begin
                            sb_we      = 1'b1;
                            cnt_b_next = cnt_b_reg + 1'b1;
                        end
                        else
                        begin
                            sa_we      = 1'b1;
                            cnt_a_next = cnt_a_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_SCAN_NEXT:
            begin
                if ({1'b0, cy_reg} == eff_h - 1'b1)
                begin
                    cy_next = '0;
                    cx_next = cx_reg + 1'b1;
                end
                else
                begin
                    cy_next = cy_reg + 1'b1;
                end
            end
            ST_LOOP_CHK:
            begin
                scan_next = 1'b0;
                if (cnt_a_reg != '0)
                begin
                    gen_next   = gen_step(gen_reg);
                    src_b_next = 1'b0;
                end
            end
            ST_DRAIN:
            begin
                if (!cnt_src_zero)
                begin
                    // pop: read the top entry of the source stack
                    if (src_b_reg)
                    begin
                        cnt_b_next = cnt_b_reg - 1'b1;
                        sb_addr    = cnt_b_next[SAW-1:0];
                    end
                    else
                    begin
                        cnt_a_next = cnt_a_reg - 1'b1;
                        sa_addr    = cnt_a_next[SAW-1:0];
                    end
                end
                else if (!src_b_reg)
                begin
                    gen_next   = gen_step(gen_reg);
                    src_b_next = 1'b1;
                end
            end
            ST_POP_WAIT:
            begin
                if (src_b_reg)
                begin
                    cx_next = sb_rdata[XW-1:0];
                    cy_next = sb_rdata[GAW-1:XW];
                end
                else
                begin
                    cx_next = sa_rdata[XW-1:0];
                    cy_next = sa_rdata[GAW-1:XW];
                end
            end
            ST_DONE:
            begin
                pass_count_next = {1'b0, gen_reg} - 9'd6;
                ovf_out_next    = ovf_reg;
                out_valid_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            grid_width_reg  <= CFG_DATA_W'(64);
            grid_height_reg <= CFG_DATA_W'(64);
            gen_reg         <= GEN_START;
            cnt_a_reg       <= '0;
            cnt_b_reg       <= '0;
            scan_reg        <= 1'b0;
            src_b_reg       <= 1'b0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            gen_reg         <= gen_next;
            cnt_a_reg       <= cnt_a_next;
            cnt_b_reg       <= cnt_b_next;
            scan_reg        <= scan_next;
            src_b_reg       <= src_b_next;
            ovf_reg         <= ovf_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        nb_idx_reg     <= nb_idx_next;
        mask_reg       <= mask_next;
        inmap_reg      <= inmap_next;
        rd_ok_reg      <= rd_ok_next;
        read_value_reg <= read_value_next;
        pass_count_reg <= pass_count_next;
        ovf_out_reg    <= ovf_out_next;
    end

endmodule

[hdl/gdep_ram.sv]
`timescale 1ns / 1ps
module gdep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hdl/gdep_nbr.sv]
`timescale 1ns / 1ps
module gdep_nbr import gdep_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic [$clog2(MAX_DIM)-1:0] cx,
    input  logic [$clog2(MAX_DIM)-1:0] cy,
    input  logic [2:0]                 idx,
    input  logic [$clog2(MAX_DIM):0]   eff_w,
    input  logic [$clog2(MAX_DIM):0]   eff_h,
    output logic [$clog2(MAX_DIM)-1:0] nx,
    output logic [$clog2(MAX_DIM)-1:0] ny,
    output logic                       in_map
);

    localparam int XW = $clog2(MAX_DIM);

    logic [1:0]           dx;
    logic [1:0]           dy;
    logic signed [XW+1:0] sx;
    logic signed [XW+1:0] sy;

    always_comb
    begin
        dx = nb_dx(idx);
        dy = nb_dy(idx);
        sx = $signed({2'b00, cx}) + $signed({{XW{dx[1]}}, dx});
        sy = $signed({2'b00, cy}) + $signed({{XW{dy[1]}}, dy});
        in_map = (sx >= 0) && (sy >= 0) &&
                 (sx < $signed({1'b0, eff_w})) && (sy < $signed({1'b0, eff_h}));
        nx = sx[XW-1:0];
        ny = sy[XW-1:0];
    end

endmodule
